// ===== hw/rtl/nppl_pkg.sv =====
// Shared types and constants for the prime power lookup block.
package nppl_pkg;

    // Width of the query index, the limit register and the listed values.
    localparam int VALUE_W = 16;

    // Reset value of the limit register.
    localparam logic [VALUE_W-1:0] LIMIT_RESET = 16'hFFFF;

    // Byte address of the limit register on the register port.
    localparam logic [2:0] REG_VALUE_LIMIT = 3'd0;

    // Bit positions inside one entry of the mark memory.
    localparam int MARK_W    = 2;
    localparam int MARK_COMP = 0;
    localparam int MARK_POW  = 1;

    // Operations of the shared arithmetic unit.
    typedef enum logic {
        ALU_ADD,
        ALU_MUL
    } t_alu_op;

    // Results of the shared arithmetic unit that steer the sequencer.
    typedef struct packed {
        logic le_lim;
    } t_alu_flags;

endpackage

// ===== hw/rtl/nth_prime_power_lookup_core.sv =====
// Top level: a query after a rebuild first waits for the clear, sieve, power marking and collect
// passes over the mark memory, each running up to L, the clamped limit.
// All passes run through one shared add/multiply unit, one step per cycle.
// With the list built, a query passes through the list read and response states, paced by
// the registered read of the list memory; new queries are accepted only while the block is idle.
// Synchronous active-low reset clears control state and sets the limit to 65535.
module nth_prime_power_lookup_core
    import nppl_pkg::*;
#(
    parameter int MAX_VALUE  = 65536,
    parameter int LIST_DEPTH = 8192
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [VALUE_W-1:0] i_query_index,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_found,
    output logic [VALUE_W-1:0] o_power_value
);

    localparam int VW = $clog2(MAX_VALUE);
    localparam int LW = $clog2(LIST_DEPTH);

    logic [VALUE_W-1:0] r_value_limit;
    logic               cfg_we;
    logic               limit_sel;

    t_alu_op     alu_op;
    logic [VW:0] alu_a;
    logic [VW:0] alu_b;
    logic [VW-1:0] alu_lim;
    logic [VW:0] alu_res;
    t_alu_flags  alu_flags;

    logic              mark_we;
    logic [VW-1:0]     mark_waddr;
    logic [MARK_W-1:0] mark_wdata;
    logic [VW-1:0]     mark_raddr;
    logic [MARK_W-1:0] mark_rdata;

    logic               list_we;
    logic [LW-1:0]      list_waddr;
    logic [VALUE_W-1:0] list_wdata;
    logic [LW-1:0]      list_raddr;
    logic [VALUE_W-1:0] list_rdata;

    // Register decode: the limit register sits at byte address zero.
    assign limit_sel = (paddr[2] == REG_VALUE_LIMIT[2]);
    assign cfg_we    = psel && penable && pwrite && limit_sel;
    assign pready    = 1'b1;
    assign prdata    = limit_sel ? 32'(r_value_limit) : 32'd0;

    // Limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_limit <= LIMIT_RESET;
        end else if (cfg_we) begin
            r_value_limit <= pwdata[VALUE_W-1:0];
        end
    end

    // Sequencer for the build passes and the query path.
    nppl_ctrl #(
        .MAX_VALUE  (MAX_VALUE),
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_limit       (r_value_limit),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_query_index (i_query_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_power_value (o_power_value),
        .o_alu_op      (alu_op),
        .o_alu_a       (alu_a),
        .o_alu_b       (alu_b),
        .o_alu_lim     (alu_lim),
        .i_alu_res     (alu_res),
        .i_alu_flags   (alu_flags),
        .o_mark_we     (mark_we),
        .o_mark_waddr  (mark_waddr),
        .o_mark_wdata  (mark_wdata),
        .o_mark_raddr  (mark_raddr),
        .i_mark_rdata  (mark_rdata),
        .o_list_we     (list_we),
        .o_list_waddr  (list_waddr),
        .o_list_wdata  (list_wdata),
        .o_list_raddr  (list_raddr),
        .i_list_rdata  (list_rdata)
    );

    // Shared arithmetic unit.
    nppl_alu #(
        .VW (VW)
    ) u_alu (
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_lim   (alu_lim),
        .o_res   (alu_res),
        .o_flags (alu_flags)
    );

    // Composite and power marks, one entry per value.
    nppl_ram #(
        .WIDTH (MARK_W),
        .DEPTH (MAX_VALUE)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    // Ascending list of prime powers.
    nppl_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (LIST_DEPTH)
    ) u_list_ram (
        .i_clk   (i_clk),
        .i_we    (list_we),
        .i_waddr (list_waddr),
        .i_wdata (list_wdata),
        .i_raddr (list_raddr),
        .o_rdata (list_rdata)
    );

endmodule

// ===== hw/rtl/nppl_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module nppl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/nppl_alu.sv =====
// Shared add and multiply unit with a compare against the active limit.
module nppl_alu
    import nppl_pkg::*;
#(
    parameter int VW = 16
) (
    input  t_alu_op       i_op,
    input  logic [VW:0]   i_a,
    input  logic [VW:0]   i_b,
    input  logic [VW-1:0] i_lim,
    output logic [VW:0]   o_res,
    output t_alu_flags    o_flags
);

    localparam int AW = VW + 1;
    localparam int PW = 2 * AW;

    logic [PW-1:0] full_res;

    // Full-width result, so that the compare sees any overflow past the limit.
    always_comb begin
        case (i_op)
            ALU_MUL: full_res = PW'(i_a) * PW'(i_b);
            default: full_res = PW'(i_a) + PW'(i_b);
        endcase
    end

    assign o_res          = full_res[AW-1:0];
    assign o_flags.le_lim = (full_res <= PW'(i_lim));

endmodule

// ===== hw/rtl/nppl_ctrl.sv =====
// Sequencer that builds the prime power list and answers queries from it.
module nppl_ctrl
    import nppl_pkg::*;
#(
    parameter int MAX_VALUE  = 65536,
    parameter int LIST_DEPTH = 8192
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [VALUE_W-1:0]            i_limit,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [VALUE_W-1:0]            i_query_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_found,
    output logic [VALUE_W-1:0]            o_power_value,
    output t_alu_op                       o_alu_op,
    output logic [$clog2(MAX_VALUE):0]    o_alu_a,
    output logic [$clog2(MAX_VALUE):0]    o_alu_b,
    output logic [$clog2(MAX_VALUE)-1:0]  o_alu_lim,
    input  logic [$clog2(MAX_VALUE):0]    i_alu_res,
    input  t_alu_flags                    i_alu_flags,
    output logic                          o_mark_we,
    output logic [$clog2(MAX_VALUE)-1:0]  o_mark_waddr,
    output logic [MARK_W-1:0]             o_mark_wdata,
    output logic [$clog2(MAX_VALUE)-1:0]  o_mark_raddr,
    input  logic [MARK_W-1:0]             i_mark_rdata,
    output logic                          o_list_we,
    output logic [$clog2(LIST_DEPTH)-1:0] o_list_waddr,
    output logic [VALUE_W-1:0]            o_list_wdata,
    output logic [$clog2(LIST_DEPTH)-1:0] o_list_raddr,
    input  logic [VALUE_W-1:0]            i_list_rdata
);

    localparam int VW   = $clog2(MAX_VALUE);
    localparam int AW   = VW + 1;
    localparam int LW   = $clog2(LIST_DEPTH);
    localparam int CNTW = $clog2(LIST_DEPTH + 1);
    localparam int CW   = (AW > VALUE_W) ? AW : VALUE_W;
    localparam int QW   = (CNTW > VALUE_W) ? CNTW : VALUE_W;
    localparam logic [CW-1:0] LIM_MAX = CW'(MAX_VALUE - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_SV_SQ,
        ST_SV_TST,
        ST_SV_MARK,
        ST_SV_NXT,
        ST_PW_NXT,
        ST_PW_RD,
        ST_PW_TST,
        ST_PW_MARK,
        ST_CL_NXT,
        ST_CL_RD,
        ST_CL_TST,
        ST_Q_RD,
        ST_Q_RSP
    } t_state;

    t_state             r_state;
    logic               r_built;
    logic [AW-1:0]      r_i;
    logic [AW-1:0]      r_j;
    logic [VW-1:0]      r_lim;
    logic [CNTW-1:0]    r_count;
    logic [VALUE_W-1:0] r_q;
    logic               r_ovalid;
    logic               r_found;
    logic [VALUE_W-1:0] r_value;

    logic [CW-1:0] lim_ext;
    logic [CW-1:0] lim_clamped;
    logic          list_full;
    logic          hit;
    logic          out_free;

    // Limit clamped to the size of the mark store.
    assign lim_ext     = CW'(i_limit);
    assign lim_clamped = (lim_ext > LIM_MAX) ? LIM_MAX : lim_ext;

    assign list_full = (r_count == CNTW'(LIST_DEPTH));
    assign hit       = (r_q != '0) && (QW'(r_q) <= QW'(r_count));
    assign out_free  = !r_ovalid || i_ready;

    // Operand selection for the shared unit; loop increments are the default.
    always_comb begin
        o_alu_op = ALU_ADD;
        o_alu_a  = r_i;
        o_alu_b  = AW'(1);
        unique case (r_state)
            ST_SV_SQ: begin
                o_alu_op = ALU_MUL;
                o_alu_b  = r_i;
            end
            ST_SV_MARK: begin
                o_alu_a = r_j;
                o_alu_b = r_i;
            end
            ST_PW_MARK: begin
                o_alu_op = ALU_MUL;
                o_alu_a  = r_j;
                o_alu_b  = r_i;
            end
            default: begin
            end
        endcase
    end

    assign o_alu_lim = r_lim;

    // Mark memory writes: clear pass, composite marks, then power marks.
    always_comb begin
        o_mark_we    = 1'b0;
        o_mark_waddr = r_j[VW-1:0];
        o_mark_wdata = '0;
        unique case (r_state)
            ST_CLR: begin
                o_mark_we    = 1'b1;
                o_mark_waddr = r_i[VW-1:0];
            end
            ST_SV_MARK: begin
                o_mark_we               = 1'b1;
                o_mark_wdata[MARK_COMP] = 1'b1;
            end
            ST_PW_MARK: begin
                o_mark_we               = 1'b1;
                o_mark_wdata[MARK_POW]  = 1'b1;
                o_mark_wdata[MARK_COMP] = (r_j != r_i);
            end
            default: begin
            end
        endcase
    end

    assign o_mark_raddr = r_i[VW-1:0];

    // List memory: appended during collection, read by each query.
    assign o_list_we    = (r_state == ST_CL_TST) && i_mark_rdata[MARK_POW] && !list_full;
    assign o_list_waddr = r_count[LW-1:0];
    assign o_list_wdata = VALUE_W'(r_i);
    assign o_list_raddr = LW'(r_q - VALUE_W'(1));

    // Sequencer state, build state and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_built  <= 1'b0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_built <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_valid) begin
                        r_q <= i_query_index;
                        if (r_built) begin
                            r_state <= ST_Q_RD;
                        end else begin
                            r_lim   <= lim_clamped[VW-1:0];
                            r_count <= '0;
                            r_i     <= '0;
                            r_state <= ST_CLR;
                        end
                    end
                end
                ST_CLR: begin
                    if (i_alu_flags.le_lim) begin
                        r_i <= i_alu_res;
                    end else begin
                        r_i     <= AW'(2);
                        r_state <= ST_SV_SQ;
                    end
                end
                ST_SV_SQ: begin
                    if (i_alu_flags.le_lim) begin
                        r_j     <= i_alu_res;
                        r_state <= ST_SV_TST;
                    end else begin
                        r_i     <= AW'(1);
                        r_state <= ST_PW_NXT;
                    end
                end
                ST_SV_TST: begin
                    if (i_mark_rdata[MARK_COMP]) begin
                        r_state <= ST_SV_NXT;
                    end else begin
                        r_state <= ST_SV_MARK;
                    end
                end
                ST_SV_MARK: begin
                    if (i_alu_flags.le_lim) begin
                        r_j <= i_alu_res;
                    end else begin
                        r_state <= ST_SV_NXT;
                    end
                end
                ST_SV_NXT: begin
                    r_i     <= i_alu_res;
                    r_state <= ST_SV_SQ;
                end
                ST_PW_NXT: begin
                    if (i_alu_flags.le_lim) begin
                        r_i     <= i_alu_res;
                        r_state <= ST_PW_RD;
                    end else begin
                        r_i     <= AW'(1);
                        r_state <= ST_CL_NXT;
                    end
                end
                ST_PW_RD: begin
                    r_state <= ST_PW_TST;
                end
                ST_PW_TST: begin
                    if (i_mark_rdata[MARK_COMP]) begin
                        r_state <= ST_PW_NXT;
                    end else begin
                        r_j     <= r_i;
                        r_state <= ST_PW_MARK;
                    end
                end
                ST_PW_MARK: begin
                    if (i_alu_flags.le_lim) begin
                        r_j <= i_alu_res;
                    end else begin
                        r_state <= ST_PW_NXT;
                    end
                end
                ST_CL_NXT: begin
                    if (i_alu_flags.le_lim) begin
                        r_i     <= i_alu_res;
                        r_state <= ST_CL_RD;
                    end else begin
                        r_built <= 1'b1;
                        r_state <= ST_Q_RD;
                    end
                end
                ST_CL_RD: begin
                    r_state <= ST_CL_TST;
                end
                ST_CL_TST: begin
                    if (i_mark_rdata[MARK_POW] && !list_full) begin
                        r_count <= r_count + CNTW'(1);
                    end
                    r_state <= ST_CL_NXT;
                end
                ST_Q_RD: begin
                    r_state <= ST_Q_RSP;
                end
                ST_Q_RSP: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_found  <= hit;
                        r_value  <= hit ? i_list_rdata : '0;
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_valid       = r_ovalid;
    assign o_found       = r_found;
    assign o_power_value = r_value;

endmodule

// ===== hw/rtl/nppl_checker.sv =====
// Port-level checker for the prime power lookup block, with its bind statement.
module nppl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        pready,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_found,
    input logic [15:0] o_power_value
);

    // The register port never inserts wait states.
    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |-> pready)
        else $error("pready dropped low");

    // An accepted query keeps the block busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted twice in back-to-back cycles");

    // A miss always carries a zero value.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_power_value == 16'd0))
        else $error("not-found transaction carries a nonzero value");

    // A hit is always a prime power, so at least two.
    a_hit_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_power_value > 16'd1))
        else $error("found transaction carries a value below two");

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_found) && $stable(o_power_value)))
        else $error("stalled result transaction changed");

endmodule

bind nth_prime_power_lookup_core nppl_checker u_nppl_checker (.*);
